FILE: rtl/core/kvt_pkg.sv
// Package for the key/value table: shared constants, codes and types.
// Used by the controller, datapath and top level under rtl/core; depends on nothing else.
package kvt_pkg;

    // Default table capacity in entries.
    localparam int unsigned CAPACITY_DEF = 64;

    // Fixed field widths of the operation and result transfers.
    localparam int unsigned OPC_W   = 2;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned STS_W   = 2;
    localparam int unsigned COUNT_W = 7;

    // Operation codes.
    typedef enum logic [OPC_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    // Result status codes.
    typedef enum logic [STS_W-1:0] {
        STS_DONE = 2'd0,
        STS_MISS = 2'd1,
        STS_FULL = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EXEC,
        S_RESP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;  // Clear one key-memory entry and step the index.
        logic load;   // Capture a new operation and restart the scan.
        logic scan;   // Read one key-memory entry and step the index.
        logic exec;   // Apply the memory writes and the count update.
        logic resp;   // Load the result registers.
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_last;  // The index points at the last entry.
    } t_dp_stat;

endpackage

FILE: rtl/core/kvt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; instantiated by the key/value table datapath.
module kvt_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/kvt_ctrl.sv
// Controller of the key/value table: sequences clear, scan, execute and respond.
// Depends on kvt_pkg.
module kvt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    output logic               o_valid,
    output kvt_pkg::t_dp_cmd   o_cmd,
    input  kvt_pkg::t_dp_stat  i_stat
);
    import kvt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    // State register and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_stat.idx_last) n_state = S_IDLE;
            S_IDLE:  if (start)           n_state = S_SCAN;
            S_SCAN:  if (i_stat.idx_last) n_state = S_DRAIN;
            S_DRAIN: n_state = S_EXEC;
            S_EXEC:  n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Output logic: datapath commands, busy and the strobe's next value.
    always_comb begin
        o_cmd   = '0;
        busy    = 1'b1;
        n_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clear = 1'b1;
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_SCAN:  o_cmd.scan = 1'b1;
            S_DRAIN: ;
            S_EXEC:  o_cmd.exec = 1'b1;
            S_RESP: begin
                o_cmd.resp = 1'b1;
                n_valid    = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_valid = r_valid;

endmodule

FILE: rtl/core/kvt_dp.sv
// Datapath of the key/value table: key and value memories, scan compare,
// entry count and result registers. Depends on kvt_pkg and kvt_ram.
module kvt_dp #(
    parameter int unsigned CAPACITY = kvt_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  kvt_pkg::t_dp_cmd                 i_cmd,
    output kvt_pkg::t_dp_stat                o_stat,
    input  logic [kvt_pkg::OPC_W-1:0]        i_opcode,
    input  logic [kvt_pkg::KEY_W-1:0]        i_key,
    input  logic [kvt_pkg::VAL_W-1:0]        i_new_value,
    output logic [kvt_pkg::STS_W-1:0]        o_status,
    output logic [kvt_pkg::VAL_W-1:0]        o_read_value,
    output logic [kvt_pkg::COUNT_W-1:0]      o_entry_count
);
    import kvt_pkg::*;

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned ENT_W = KEY_W + 1;  // Valid mark above the key.

    // Captured operation.
    t_opcode            r_op;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_value;

    // Scan index and compare pipeline.
    logic [IDX_W-1:0]   r_idx;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic               r_free;
    logic [IDX_W-1:0]   r_free_idx;
    logic [CNT_W-1:0]   r_count;

    // Result registers.
    t_status            r_status;
    logic [VAL_W-1:0]   r_rdata;

    // Memory ports.
    logic               key_we;
    logic [IDX_W-1:0]   key_waddr;
    logic [ENT_W-1:0]   key_wdata;
    logic [ENT_W-1:0]   key_rdata;
    logic               val_we;
    logic [IDX_W-1:0]   val_waddr;
    logic [VAL_W-1:0]   val_rdata;
    logic [IDX_W-1:0]   tgt_idx;
    logic               do_insert;
    logic               do_remove;
    logic               ent_match;
    logic               ent_free;

    assign o_stat.idx_last = (r_idx == IDX_W'(CAPACITY - 1));

    // Operation capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_opcode'(i_opcode);
            r_key   <= i_key;
            r_value <= i_new_value;
        end
    end

    // The compare looks at the entry read in the previous cycle.
    assign ent_match = r_cmp_vld && key_rdata[ENT_W-1] && (key_rdata[KEY_W-1:0] == r_key);
    assign ent_free  = r_cmp_vld && !key_rdata[ENT_W-1];

    // Scan index, compare pipeline and first-hit / first-free tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
            if (i_cmd.load) begin
                r_idx  <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else begin
                if (i_cmd.clear || i_cmd.scan) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (ent_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (ent_free && !r_free) begin
                    r_free <= 1'b1;
                end
            end
        end
    end

    // Slot indexes found by the scan.
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (ent_match && !r_hit) begin
            r_hit_idx <= r_cmp_idx;
        end
        if (ent_free && !r_free) begin
            r_free_idx <= r_cmp_idx;
        end
    end

    // Write decisions for the execute step.
    assign do_insert = i_cmd.exec && (r_op == OP_ADD) && !r_hit && r_free;
    assign do_remove = i_cmd.exec && (r_op == OP_REMOVE) && r_hit;
    assign tgt_idx   = r_hit ? r_hit_idx : r_free_idx;

    assign key_we    = i_cmd.clear || do_insert || do_remove;
    assign key_waddr = i_cmd.clear ? r_idx : tgt_idx;
    assign key_wdata = i_cmd.clear ? '0 : {do_insert, r_key};

    assign val_we    = i_cmd.exec && (r_op == OP_ADD) && (r_hit || r_free);
    assign val_waddr = tgt_idx;

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (do_insert) begin
            r_count <= r_count + 1'b1;
        end else if (do_remove) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Result registers, loaded once the memory writes and count have settled.
    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            r_rdata <= '0;
            unique case (r_op)
                OP_ADD:    r_status <= (r_hit || r_free) ? STS_DONE : STS_FULL;
                OP_REMOVE: r_status <= r_hit ? STS_DONE : STS_MISS;
                OP_LOOKUP: begin
                    r_status <= r_hit ? STS_DONE : STS_MISS;
                    if (r_hit) begin
                        r_rdata <= val_rdata;
                    end
                end
                OP_NOP:    r_status <= STS_DONE;
                default:   r_status <= STS_DONE;
            endcase
        end
    end

    // Key memory: each word holds a valid mark and the key.
    kvt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (key_wdata),
        .i_raddr (r_idx),
        .o_rdata (key_rdata)
    );

    // Value memory, read at the hit slot.
    kvt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (r_value),
        .i_raddr (r_hit_idx),
        .o_rdata (val_rdata)
    );

    assign o_status      = r_status;
    assign o_read_value  = r_rdata;
    assign o_entry_count = COUNT_W'(r_count);

endmodule

FILE: rtl/core/key_value_table.sv
// Key/value table top level: controller plus datapath. Depends on kvt_pkg,
// kvt_ctrl, kvt_dp and kvt_ram. A new operation is taken only once the previous
// one has finished; each runs a scan of the key memory, one entry per cycle.
// After reset a clearing pass over every key-memory entry runs with busy high.
// The o_valid strobe lasts one cycle; the receiver cannot stall.
module key_value_table #(
    parameter int unsigned CAPACITY = kvt_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [kvt_pkg::OPC_W-1:0]          i_opcode,
    input  logic signed [kvt_pkg::KEY_W-1:0]   i_key,
    input  logic signed [kvt_pkg::VAL_W-1:0]   i_new_value,
    output logic                               o_valid,
    output logic [kvt_pkg::STS_W-1:0]          o_status,
    output logic signed [kvt_pkg::VAL_W-1:0]   o_read_value,
    output logic [kvt_pkg::COUNT_W-1:0]        o_entry_count
);
    import kvt_pkg::*;

    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;
    logic [VAL_W-1:0] read_value;

    // Sequencing.
    kvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    // Storage, compare and results.
    kvt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_new_value   (i_new_value),
        .o_status      (o_status),
        .o_read_value  (read_value),
        .o_entry_count (o_entry_count)
    );

    assign o_read_value = $signed(read_value);

    // The result strobe only appears while a new transfer can be taken.
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted operation keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted operation did not raise busy");

    // A nonzero read value only comes with a successful result.
    a_value_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_read_value != '0)) |-> (o_status == STS_DONE))
        else $error("read value on an unsuccessful result");

    // Only one datapath command is issued at a time.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(dp_cmd))
        else $error("conflicting datapath commands");

endmodule
